### rtl/rep_pkg.sv
`timescale 1ns / 1ps
// rep_pkg: port widths, register indexes and micro-op codes for ray_edge_pick.
// No dependencies; imported by ray_edge_pick.
package rep_pkg;

    localparam int IN_TDATA_W  = 192;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int EDGE_W      = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_ORG_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd6;

    typedef logic [5:0] t_pc;
    typedef logic [1:0] t_kind;
    typedef logic [4:0] t_src;
    typedef logic [2:0] t_pre;
    typedef logic [3:0] t_dst;

    localparam t_kind K_CTL = 2'd0;
    localparam t_kind K_MUL = 2'd1;
    localparam t_kind K_DIV = 2'd2;

    localparam t_src S_D0   = 5'd0;
    localparam t_src S_D1   = 5'd1;
    localparam t_src S_D2   = 5'd2;
    localparam t_src S_R0   = 5'd3;
    localparam t_src S_R1   = 5'd4;
    localparam t_src S_R2   = 5'd5;
    localparam t_src S_G0   = 5'd6;
    localparam t_src S_G1   = 5'd7;
    localparam t_src S_G2   = 5'd8;
    localparam t_src S_A    = 5'd9;
    localparam t_src S_E    = 5'd10;
    localparam t_src S_F    = 5'd11;
    localparam t_src S_C    = 5'd12;
    localparam t_src S_B    = 5'd13;
    localparam t_src S_NUM  = 5'd14;
    localparam t_src S_DEN  = 5'd15;
    localparam t_src S_NT   = 5'd16;
    localparam t_src S_U    = 5'd17;
    localparam t_src S_T    = 5'd18;
    localparam t_src S_DF   = 5'd19;
    localparam t_src S_ONE  = 5'd20;

    localparam t_pre PL_KEEP = 3'd0;
    localparam t_pre PL_ZERO = 3'd1;
    localparam t_pre PL_FSH  = 3'd2;
    localparam t_pre PL_B    = 3'd3;
    localparam t_pre PL_R0   = 3'd4;
    localparam t_pre PL_R1   = 3'd5;
    localparam t_pre PL_R2   = 3'd6;
    localparam t_pre PL_SUM  = 3'd7;

    localparam t_dst DS_NONE = 4'd0;
    localparam t_dst DS_A    = 4'd1;
    localparam t_dst DS_E    = 4'd2;
    localparam t_dst DS_F    = 4'd3;
    localparam t_dst DS_C    = 4'd4;
    localparam t_dst DS_B    = 4'd5;
    localparam t_dst DS_DEN  = 4'd6;
    localparam t_dst DS_NUM  = 4'd7;
    localparam t_dst DS_NT   = 4'd8;
    localparam t_dst DS_U    = 4'd9;
    localparam t_dst DS_T    = 4'd10;
    localparam t_dst DS_DF   = 4'd11;
    localparam t_dst DS_SUM  = 4'd12;

    localparam logic HI_ONE = 1'b0;
    localparam logic HI_FAR = 1'b1;

    typedef struct packed {
        t_kind kind;
        t_src  xs;
        t_src  ys;
        logic  sub;
        t_pre  pre;
        t_dst  dst;
        logic  shf;
        logic  hi;
        t_pc   nxt;
    } t_uop;

    function automatic t_uop mk(input t_kind kind, input t_src xs, input t_src ys,
                                input logic sub, input t_pre pre, input t_dst dst,
                                input logic shf, input logic hi, input t_pc nxt);
        t_uop u;
        u.kind = kind;
        u.xs   = xs;
        u.ys   = ys;
        u.sub  = sub;
        u.pre  = pre;
        u.dst  = dst;
        u.shf  = shf;
        u.hi   = hi;
        u.nxt  = nxt;
        return u;
    endfunction

endpackage

### rtl/ray_edge_pick.sv
`timescale 1ns / 1ps
// ray_edge_pick: nearest edge to a pick ray, one shared add/subtract unit under a sequencer.
// Depends on rep_pkg.
//
// One edge beat is taken at a time; s_axis_tready is high only while the block is idle.
// An edge inside the first MAX_EDGES runs a micro-op sequence on the shared unit; each
// product runs bit-serially through the one shared adder, shifting the multiplier until
// its remaining bits are zero (so short operands finish sooner; at most 30 products per
// edge), and each of at most two divisions runs as restoring steps on the same adder.
// Edges past MAX_EDGES skip the sequence. The result beat appears after the edge marked tlast
// and is held until taken. Configuration writes land at once and must come while idle.
module ray_edge_pick #(
    parameter int MAX_EDGES    = 1024,
    parameter int FAR_DISTANCE = 1000000,
    parameter int FRAC_BITS    = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z (32 bits each)
    input  logic [rep_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // hit_found [0], hit_edge [10:1], zero fill
    output logic [rep_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [rep_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rep_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import rep_pkg::*;

    localparam int W    = FRAC_BITS + 122;
    localparam int U_W  = $clog2(FAR_DISTANCE + 1) + FRAC_BITS;
    localparam int T_W  = FRAC_BITS + 1;
    localparam int CW   = $clog2(MAX_EDGES + 1);
    localparam int DC_W = $clog2(W + 1);
    localparam logic [U_W-1:0] FAR_RAW = U_W'(FAR_DISTANCE) << FRAC_BITS;
    localparam logic [T_W-1:0] ONE_T   = T_W'(1) << FRAC_BITS;
    // squared length at most 1e-6 in Q.2F
    localparam logic [63:0]    TE_MAX  = (64'd1 << (2 * FRAC_BITS)) / 64'd1000000;

    localparam t_pc P_IDLE  = 6'd0;
    localparam t_pc P_A0    = 6'd1;
    localparam t_pc P_A1    = 6'd2;
    localparam t_pc P_A2    = 6'd3;
    localparam t_pc P_E0    = 6'd4;
    localparam t_pc P_E1    = 6'd5;
    localparam t_pc P_E2    = 6'd6;
    localparam t_pc P_F0    = 6'd7;
    localparam t_pc P_F1    = 6'd8;
    localparam t_pc P_F2    = 6'd9;
    localparam t_pc P_CHK1  = 6'd10;
    localparam t_pc P_TDIV1 = 6'd11;
    localparam t_pc P_C0    = 6'd12;
    localparam t_pc P_C1    = 6'd13;
    localparam t_pc P_C2    = 6'd14;
    localparam t_pc P_CHK2  = 6'd15;
    localparam t_pc P_UDIVC = 6'd16;
    localparam t_pc P_B0    = 6'd17;
    localparam t_pc P_B1    = 6'd18;
    localparam t_pc P_B2    = 6'd19;
    localparam t_pc P_DEN0  = 6'd20;
    localparam t_pc P_DEN1  = 6'd21;
    localparam t_pc P_CHK3  = 6'd22;
    localparam t_pc P_NUM0  = 6'd23;
    localparam t_pc P_NUM1  = 6'd24;
    localparam t_pc P_UDIVN = 6'd25;
    localparam t_pc P_NT0   = 6'd26;
    localparam t_pc P_CHK4  = 6'd27;
    localparam t_pc P_BC    = 6'd28;
    localparam t_pc P_UDIVB = 6'd29;
    localparam t_pc P_TDIV2 = 6'd30;
    localparam t_pc P_D0    = 6'd31;
    localparam t_pc P_D1    = 6'd32;
    localparam t_pc P_D2    = 6'd33;
    localparam t_pc P_D3    = 6'd34;
    localparam t_pc P_D4    = 6'd35;
    localparam t_pc P_D5    = 6'd36;
    localparam t_pc P_D6    = 6'd37;
    localparam t_pc P_D7    = 6'd38;
    localparam t_pc P_D8    = 6'd39;
    localparam t_pc P_CMP   = 6'd40;
    localparam t_pc P_OUT   = 6'd41;

    // configuration
    logic signed [31:0] r_org [3];
    logic signed [17:0] r_dir [3];
    logic [30:0]        r_rad;
    logic [61:0]        r_rsq;

    // pick state
    logic [CW-1:0]     r_ecnt;
    logic [63:0]       r_bestd;
    logic [EDGE_W-1:0] r_beste;
    logic              r_hit;

    // per-edge values
    logic signed [32:0]  r_rv [3];
    logic signed [32:0]  r_gv [3];
    logic                r_last;
    logic signed [W-1:0] r_a, r_e, r_f, r_c, r_b, r_denv, r_num, r_nt, r_df, r_sum;
    logic [U_W-1:0]      r_u;
    logic [T_W-1:0]      r_t;

    // shared unit
    t_pc                 r_pc;
    logic                r_run;
    logic                r_isdiv;
    logic signed [W-1:0] r_acc;
    logic [W-1:0]        r_mx;
    logic [63:0]         r_my;
    logic                r_neg;
    logic [W-1:0]        r_rem, r_dq, r_dend;
    logic [DC_W-1:0]     r_dcnt;
    logic                r_hifar;

    logic              r_ovalid, r_ofound;
    logic [EDGE_W-1:0] r_oedge;

    t_uop                uop;
    logic signed [W-1:0] x_val, y_val, pre_val, div_num;
    logic [W-1:0]        x_mag, y_mag, alu_a, alu_b, hi_w, q_clamp;
    logic                alu_sub;
    logic [W:0]          alu;
    logic                u_done, op_start, op_wb, accept;
    logic signed [W-1:0] res;
    logic                ta, te, den_zero, nt_neg, e_lt_nt, better;
    logic [W-1:0]        sum_sh;
    logic [63:0]         dsq;

    function automatic logic signed [W-1:0] src_val(input t_src code);
        logic signed [W-1:0] v;
        unique case (code)
            S_D0:    v = W'(r_dir[0]);
            S_D1:    v = W'(r_dir[1]);
            S_D2:    v = W'(r_dir[2]);
            S_R0:    v = W'(r_rv[0]);
            S_R1:    v = W'(r_rv[1]);
            S_R2:    v = W'(r_rv[2]);
            S_G0:    v = W'(r_gv[0]);
            S_G1:    v = W'(r_gv[1]);
            S_G2:    v = W'(r_gv[2]);
            S_A:     v = r_a;
            S_E:     v = r_e;
            S_F:     v = r_f;
            S_C:     v = r_c;
            S_B:     v = r_b;
            S_NUM:   v = r_num;
            S_DEN:   v = r_denv;
            S_NT:    v = r_nt;
            S_U:     v = signed'(W'(r_u));
            S_T:     v = signed'(W'(r_t));
            S_DF:    v = r_df;
            default: v = W'(1);
        endcase
        return v;
    endfunction

    // micro-op decode
    always_comb begin
        uop = mk(K_CTL, S_ONE, S_ONE, 1'b0, PL_KEEP, DS_NONE, 1'b0, HI_ONE, P_IDLE);
        unique case (r_pc)
            P_A0:    uop = mk(K_MUL, S_D0, S_D0, 1'b0, PL_ZERO, DS_NONE, 1'b0, HI_ONE, P_A1);
            P_A1:    uop = mk(K_MUL, S_D1, S_D1, 1'b0, PL_KEEP, DS_NONE, 1'b0, HI_ONE, P_A2);
            P_A2:    uop = mk(K_MUL, S_D2, S_D2, 1'b0, PL_KEEP, DS_A, 1'b0, HI_ONE, P_E0);
            P_E0:    uop = mk(K_MUL, S_G0, S_G0, 1'b0, PL_ZERO, DS_NONE, 1'b0, HI_ONE, P_E1);
            P_E1:    uop = mk(K_MUL, S_G1, S_G1, 1'b0, PL_KEEP, DS_NONE, 1'b0, HI_ONE, P_E2);
            P_E2:    uop = mk(K_MUL, S_G2, S_G2, 1'b0, PL_KEEP, DS_E, 1'b0, HI_ONE, P_F0);
            P_F0:    uop = mk(K_MUL, S_R0, S_G0, 1'b0, PL_ZERO, DS_NONE, 1'b0, HI_ONE, P_F1);
            P_F1:    uop = mk(K_MUL, S_R1, S_G1, 1'b0, PL_KEEP, DS_NONE, 1'b0, HI_ONE, P_F2);
            P_F2:    uop = mk(K_MUL, S_R2, S_G2, 1'b0, PL_KEEP, DS_F, 1'b0, HI_ONE, P_CHK1);
            P_TDIV1: uop = mk(K_DIV, S_F, S_E, 1'b0, PL_KEEP, DS_T, 1'b1, HI_ONE, P_D0);
            P_C0:    uop = mk(K_MUL, S_R0, S_D0, 1'b0, PL_ZERO, DS_NONE, 1'b0, HI_ONE, P_C1);
            P_C1:    uop = mk(K_MUL, S_R1, S_D1, 1'b0, PL_KEEP, DS_NONE, 1'b0, HI_ONE, P_C2);
            P_C2:    uop = mk(K_MUL, S_R2, S_D2, 1'b0, PL_KEEP, DS_C, 1'b0, HI_ONE, P_CHK2);
            P_UDIVC: uop = mk(K_DIV, S_C, S_A, 1'b1, PL_KEEP, DS_U, 1'b1, HI_FAR, P_D0);
            P_B0:    uop = mk(K_MUL, S_G0, S_D0, 1'b0, PL_ZERO, DS_NONE, 1'b0, HI_ONE, P_B1);
            P_B1:    uop = mk(K_MUL, S_G1, S_D1, 1'b0, PL_KEEP, DS_NONE, 1'b0, HI_ONE, P_B2);
            P_B2:    uop = mk(K_MUL, S_G2, S_D2, 1'b0, PL_KEEP, DS_B, 1'b0, HI_ONE, P_DEN0);
            P_DEN0:  uop = mk(K_MUL, S_E, S_A, 1'b0, PL_ZERO, DS_NONE, 1'b0, HI_ONE, P_DEN1);
            P_DEN1:  uop = mk(K_MUL, S_B, S_B, 1'b1, PL_KEEP, DS_DEN, 1'b0, HI_ONE, P_CHK3);
            P_NUM0:  uop = mk(K_MUL, S_F, S_B, 1'b0, PL_ZERO, DS_NONE, 1'b0, HI_ONE, P_NUM1);
            P_NUM1:  uop = mk(K_MUL, S_E, S_C, 1'b1, PL_KEEP, DS_NUM, 1'b0, HI_ONE, P_UDIVN);
            P_UDIVN: uop = mk(K_DIV, S_NUM, S_DEN, 1'b0, PL_KEEP, DS_U, 1'b1, HI_FAR, P_NT0);
            P_NT0:   uop = mk(K_MUL, S_B, S_U, 1'b0, PL_FSH, DS_NT, 1'b0, HI_ONE, P_CHK4);
            P_BC:    uop = mk(K_MUL, S_C, S_ONE, 1'b1, PL_B, DS_NUM, 1'b0, HI_ONE, P_UDIVB);
            P_UDIVB: uop = mk(K_DIV, S_NUM, S_A, 1'b0, PL_KEEP, DS_U, 1'b1, HI_FAR, P_D0);
            P_TDIV2: uop = mk(K_DIV, S_NT, S_E, 1'b0, PL_KEEP, DS_T, 1'b0, HI_ONE, P_D0);
            P_D0:    uop = mk(K_MUL, S_U, S_D0, 1'b0, PL_R0, DS_NONE, 1'b0, HI_ONE, P_D1);
            P_D1:    uop = mk(K_MUL, S_G0, S_T, 1'b1, PL_KEEP, DS_DF, 1'b0, HI_ONE, P_D2);
            P_D2:    uop = mk(K_MUL, S_DF, S_DF, 1'b0, PL_ZERO, DS_SUM, 1'b0, HI_ONE, P_D3);
            P_D3:    uop = mk(K_MUL, S_U, S_D1, 1'b0, PL_R1, DS_NONE, 1'b0, HI_ONE, P_D4);
            P_D4:    uop = mk(K_MUL, S_G1, S_T, 1'b1, PL_KEEP, DS_DF, 1'b0, HI_ONE, P_D5);
            P_D5:    uop = mk(K_MUL, S_DF, S_DF, 1'b0, PL_SUM, DS_SUM, 1'b0, HI_ONE, P_D6);
            P_D6:    uop = mk(K_MUL, S_U, S_D2, 1'b0, PL_R2, DS_NONE, 1'b0, HI_ONE, P_D7);
            P_D7:    uop = mk(K_MUL, S_G2, S_T, 1'b1, PL_KEEP, DS_DF, 1'b0, HI_ONE, P_D8);
            P_D8:    uop = mk(K_MUL, S_DF, S_DF, 1'b0, PL_SUM, DS_SUM, 1'b0, HI_ONE, P_CMP);
            default: uop = mk(K_CTL, S_ONE, S_ONE, 1'b0, PL_KEEP, DS_NONE, 1'b0, HI_ONE, P_IDLE);
        endcase
    end

    always_comb begin
        x_val = src_val(uop.xs);
        y_val = src_val(uop.ys);
        x_mag = x_val[W-1] ? $unsigned(-x_val) : $unsigned(x_val);
        y_mag = y_val[W-1] ? $unsigned(-y_val) : $unsigned(y_val);
        div_num = uop.sub ? -x_val : x_val;
        if (uop.shf) div_num = div_num <<< FRAC_BITS;
        case (uop.pre)
            PL_KEEP: pre_val = r_acc;
            PL_ZERO: pre_val = '0;
            PL_FSH:  pre_val = r_f <<< FRAC_BITS;
            PL_B:    pre_val = r_b;
            PL_R0:   pre_val = W'(r_rv[0]) <<< FRAC_BITS;
            PL_R1:   pre_val = W'(r_rv[1]) <<< FRAC_BITS;
            PL_R2:   pre_val = W'(r_rv[2]) <<< FRAC_BITS;
            default: pre_val = r_sum;
        endcase
    end

    // shared adder: accumulate for products, trial subtract for division
    always_comb begin
        if (r_isdiv) begin
            alu_a   = {r_rem[W-2:0], r_dq[W-1]};
            alu_b   = r_dend;
            alu_sub = 1'b1;
        end else begin
            alu_a   = $unsigned(r_acc);
            alu_b   = r_mx;
            alu_sub = r_neg;
        end
        alu = {1'b0, alu_a} + {1'b0, alu_b ^ {W{alu_sub}}} + (W+1)'(alu_sub);
    end

    assign u_done   = r_isdiv ? (r_dcnt == '0) : (r_my == '0);
    assign hi_w     = r_hifar ? W'(FAR_RAW) : W'(ONE_T);
    assign q_clamp  = (r_dq > hi_w) ? hi_w : r_dq;
    assign res      = r_isdiv ? signed'(q_clamp) : r_acc;
    assign op_start = (uop.kind != K_CTL) && !r_run;
    assign op_wb    = (uop.kind != K_CTL) && r_run && u_done;
    assign accept   = s_axis_tvalid && s_axis_tready;

    // ray has zero length exactly when a == 0, since FAR_DISTANCE^2 / 1e-6 exceeds 2^48
    assign ta       = (r_a == '0);
    assign te       = $unsigned(r_e) <= W'(TE_MAX);
    assign den_zero = (r_denv == '0);
    assign nt_neg   = r_nt[W-1];
    assign e_lt_nt  = (r_e <<< FRAC_BITS) < r_nt;

    assign sum_sh   = $unsigned(r_sum) >> (2 * FRAC_BITS);
    assign dsq      = (|sum_sh[W-1:64]) ? '1 : sum_sh[63:0];
    assign better   = (dsq < {2'b00, r_rsq}) && (dsq < r_bestd);

    assign s_axis_tready = (r_pc == P_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {(OUT_TDATA_W - EDGE_W - 1)'(0), r_oedge, r_ofound};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_dir[0] <= '0;
            r_dir[1] <= '0;
            r_dir[2] <= 18'sd65536;
            r_rad    <= 31'd65536;
            r_pc     <= P_IDLE;
            r_run    <= 1'b0;
            r_ovalid <= 1'b0;
            r_ofound <= 1'b0;
            r_oedge  <= '0;
            r_ecnt   <= '0;
            r_bestd  <= '1;
            r_beste  <= '0;
            r_hit    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ORG_X:  r_org[0] <= i_cfg_data;
                    CFG_ORG_Y:  r_org[1] <= i_cfg_data;
                    CFG_ORG_Z:  r_org[2] <= i_cfg_data;
                    CFG_DIR_X:  r_dir[0] <= i_cfg_data[17:0];
                    CFG_DIR_Y:  r_dir[1] <= i_cfg_data[17:0];
                    CFG_DIR_Z:  r_dir[2] <= i_cfg_data[17:0];
                    CFG_RADIUS: r_rad    <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            if (op_start) r_run <= 1'b1;
            if (op_wb) begin
                r_run <= 1'b0;
                r_pc  <= uop.nxt;
            end
            unique case (r_pc)
                P_IDLE: begin
                    if (accept) begin
                        if (r_ecnt < CW'(MAX_EDGES)) r_pc <= P_A0;
                        else if (s_axis_tlast) r_pc <= P_OUT;
                    end
                end
                P_CHK1: begin
                    if (ta) r_pc <= te ? P_D0 : P_TDIV1;
                    else r_pc <= P_C0;
                end
                P_CHK2: r_pc <= te ? P_UDIVC : P_B0;
                P_CHK3: r_pc <= den_zero ? P_NT0 : P_NUM0;
                P_CHK4: begin
                    if (nt_neg) r_pc <= P_UDIVC;
                    else if (e_lt_nt) r_pc <= P_BC;
                    else r_pc <= P_TDIV2;
                end
                P_CMP: begin
                    if (better) begin
                        r_bestd <= dsq;
                        r_beste <= EDGE_W'(r_ecnt);
                        r_hit   <= 1'b1;
                    end
                    r_ecnt <= r_ecnt + 1'b1;
                    r_pc   <= r_last ? P_OUT : P_IDLE;
                end
                P_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_ofound <= r_hit;
                        r_oedge  <= r_hit ? r_beste : '0;
                        r_ecnt   <= '0;
                        r_bestd  <= '1;
                        r_beste  <= '0;
                        r_hit    <= 1'b0;
                        r_pc     <= P_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rsq <= r_rad * r_rad;
        if (accept) begin
            r_rv[0] <= 33'(r_org[0]) - 33'(signed'(s_axis_tdata[31:0]));
            r_rv[1] <= 33'(r_org[1]) - 33'(signed'(s_axis_tdata[63:32]));
            r_rv[2] <= 33'(r_org[2]) - 33'(signed'(s_axis_tdata[95:64]));
            r_gv[0] <= 33'(signed'(s_axis_tdata[127:96])) - 33'(signed'(s_axis_tdata[31:0]));
            r_gv[1] <= 33'(signed'(s_axis_tdata[159:128])) - 33'(signed'(s_axis_tdata[63:32]));
            r_gv[2] <= 33'(signed'(s_axis_tdata[191:160])) - 33'(signed'(s_axis_tdata[95:64]));
            r_last  <= s_axis_tlast;
        end
        if (op_start) begin
            r_isdiv <= (uop.kind == K_DIV);
            if (uop.kind == K_DIV) begin
                r_rem   <= '0;
                r_dend  <= $unsigned(y_val);
                r_hifar <= uop.hi;
                if (div_num[W-1] || div_num == '0) begin
                    r_dq   <= '0;
                    r_dcnt <= '0;
                end else begin
                    r_dq   <= $unsigned(div_num);
                    r_dcnt <= DC_W'(W);
                end
            end else begin
                r_acc <= pre_val;
                r_mx  <= x_mag;
                r_my  <= y_mag[63:0];
                r_neg <= x_val[W-1] ^ y_val[W-1] ^ uop.sub;
            end
        end else if (r_run && !u_done) begin
            if (r_isdiv) begin
                r_rem  <= alu[W] ? alu[W-1:0] : alu_a;
                r_dq   <= {r_dq[W-2:0], alu[W]};
                r_dcnt <= r_dcnt - 1'b1;
            end else begin
                if (r_my[0]) r_acc <= signed'(alu[W-1:0]);
                r_mx <= r_mx << 1;
                r_my <= r_my >> 1;
            end
        end
        if (op_wb) begin
            unique case (uop.dst)
                DS_A:    r_a    <= res;
                DS_E:    r_e    <= res;
                DS_F:    r_f    <= res;
                DS_C:    r_c    <= res;
                DS_B:    r_b    <= res;
                DS_DEN:  r_denv <= res;
                DS_NUM:  r_num  <= res;
                DS_NT:   r_nt   <= res;
                DS_U:    r_u    <= res[U_W-1:0];
                DS_T:    r_t    <= res[T_W-1:0];
                DS_DF:   r_df   <= res;
                DS_SUM:  r_sum  <= res;
                default: ;
            endcase
        end
        case (r_pc)
            P_CHK1: begin
                if (ta) r_u <= '0;
                if (ta && te) r_t <= '0;
            end
            P_CHK2: if (te) r_t <= '0;
            P_CHK3: if (den_zero) r_u <= '0;
            P_CHK4: begin
                if (nt_neg) r_t <= '0;
                else if (e_lt_nt) r_t <= ONE_T;
            end
            default: ;
        endcase
    end

    ap_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_run)
        else $error("edge port ready while shared unit busy");

    ap_busy_after_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (r_ecnt < CW'(MAX_EDGES))) |=> !s_axis_tready)
        else $error("counted edge did not start the sequencer");

    ap_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecnt <= CW'(MAX_EDGES))
        else $error("edge count past MAX_EDGES");

    ap_no_hit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_ofound) |-> (r_oedge == '0))
        else $error("edge index nonzero without a hit");

endmodule
